>>> design/acl_pkg.sv
// shared types and constants for the address cache with lru and pinned entries
// no dependencies

package acl_pkg;

    localparam int OP_W     = 2;
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 32;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ENTER  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic sweep_clr;
        logic scan_en;
        logic decide;
        logic update_en;
        logic load_out;
    } acl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sweep_done;
        logic            need_move;
    } acl_stat_t;

endpackage

>>> design/address_cache_lru_pinned.sv
// top level of the address cache: ip to mac table with lru order and pinned entries
// depends on acl_pkg, acl_ctrl, acl_datapath
// sequence: flush skips the entry scan; lookup miss, enter in place,
//   delete and full-table enter scan the memories once; lookup hit and enter with
//   replacement also run the rank update sweep, each sweep one entry a cycle
// throughput: one request at a time; the next is taken once the result is registered
// reset: rst_n async active low clears the table to invalid/temporary, order to identity

module address_cache_lru_pinned #(
    parameter int ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [acl_pkg::OP_W-1:0]      opcode,
    input  logic [acl_pkg::IP_W-1:0]      ip_addr,
    input  logic [acl_pkg::MAC_W-1:0]     mac_addr,
    input  logic                          entry_permanent,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [acl_pkg::MAC_W-1:0]     mac_out,
    output logic [acl_pkg::STATUS_W-1:0]  status,
    output logic [acl_pkg::COUNT_W-1:0]   hit_count
);
    import acl_pkg::*;

    // command and status between sequencer and datapath
    acl_cmd_t  cmd;
    acl_stat_t stat;

    // sequencer: idle, scan all entries, decide, rank update sweep, result hand-off
    acl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: entry memories, per-entry valid/pinned bits, recency ranks,
    // search registers and the output register that decouples the result side
    acl_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .opcode          (opcode),
        .ip_addr         (ip_addr),
        .mac_addr        (mac_addr),
        .entry_permanent (entry_permanent),
        .cmd             (cmd),
        .stat            (stat),
        .hit             (hit),
        .mac_out         (mac_out),
        .status          (status),
        .hit_count       (hit_count)
    );

endmodule

>>> design/acl_ctrl.sv
// request sequencer for the address cache
// depends on acl_pkg

module acl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  acl_pkg::acl_stat_t stat,
    output acl_pkg::acl_cmd_t  cmd
);
    import acl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_UPDATE = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_busy;

    assign out_busy  = out_valid_reg && out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture   = 1'b1;
                    cmd.sweep_clr = 1'b1;
                    // flush needs no search
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.op == OP_FLUSH)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.scan_en = 1'b1;
                    if (stat.sweep_done)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                cmd.decide    = 1'b1;
                cmd.sweep_clr = 1'b1;
                state_next    = stat.need_move ? S_UPDATE : S_DONE;
            end
            S_UPDATE:
            begin
                cmd.update_en = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/acl_datapath.sv
// entry storage, sweep counter, match search and recency ranks
// depends on acl_pkg

module acl_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [acl_pkg::OP_W-1:0]      opcode,
    input  logic [acl_pkg::IP_W-1:0]      ip_addr,
    input  logic [acl_pkg::MAC_W-1:0]     mac_addr,
    input  logic                          entry_permanent,
    input  acl_pkg::acl_cmd_t             cmd,
    output acl_pkg::acl_stat_t            stat,
    output logic                          hit,
    output logic [acl_pkg::MAC_W-1:0]     mac_out,
    output logic [acl_pkg::STATUS_W-1:0]  status,
    output logic [acl_pkg::COUNT_W-1:0]   hit_count
);
    import acl_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // storage without reset, masked by written bits
    logic [IP_W-1:0]  ip_mem   [ENTRIES];
    logic [MAC_W-1:0] mac_mem  [ENTRIES];
    logic [IW-1:0]    rank_mem [ENTRIES];

    logic [ENTRIES-1:0] valid_reg, pinned_reg, macw_reg, rankw_reg;

    logic [OP_W-1:0]  op_reg;
    logic [IP_W-1:0]  rip_reg;
    logic [MAC_W-1:0] rmac_reg;
    logic             rpin_reg;

    logic [CW-1:0]    cnt_reg;
    logic             rd_ok_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic [IP_W-1:0]  ip_rd_reg;
    logic [MAC_W-1:0] mac_rd_reg;
    logic [IW-1:0]    rank_rd_reg;

    logic             found_reg, fpin_reg;
    logic [IW-1:0]    fidx_reg, frank_reg;
    logic [MAC_W-1:0] fmac_reg;
    logic             vic_reg;
    logic [IW-1:0]    vidx_reg, vrank_reg;
    logic             del_reg;
    logic [IW-1:0]    didx_reg, drank_reg;
    logic [IW-1:0]    mv_idx_reg, mv_rank_reg;

    logic                res_hit_reg;
    logic [MAC_W-1:0]    res_mac_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [COUNT_W-1:0]  hit_cnt_reg;
    logic                hit_reg;
    logic [MAC_W-1:0]    mac_out_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  hit_count_reg;

    logic [IW-1:0]    rd_addr;
    logic [MAC_W-1:0] mac_eff;
    logic [IW-1:0]    rank_eff, rank_new;
    logic             sweep_on, ip_match;
    logic             ip_we, mac_we;
    logic [IW-1:0]    wr_idx;

    assign rd_addr  = cnt_reg[IW-1:0];
    assign sweep_on = cmd.scan_en || cmd.update_en;
    assign mac_eff  = macw_reg[rd_idx_reg] ? mac_rd_reg : '0;
    assign rank_eff = rankw_reg[rd_idx_reg] ? rank_rd_reg : rd_idx_reg;
    assign ip_match = valid_reg[rd_idx_reg] && (ip_rd_reg == rip_reg);

    always_comb
    begin
        if (rd_idx_reg == mv_idx_reg)
            rank_new = '0;
        else if (rank_eff < mv_rank_reg)
            rank_new = rank_eff + 1'b1;
        else
            rank_new = rank_eff;
    end

    // decide-time writes
    always_comb
    begin
        ip_we  = 1'b0;
        mac_we = 1'b0;
        wr_idx = vidx_reg;
        if (cmd.decide && op_reg == OP_ENTER)
        begin
            if (found_reg)
            begin
                wr_idx = fidx_reg;
                mac_we = !fpin_reg;
            end
            else if (vic_reg)
            begin
                ip_we  = 1'b1;
                mac_we = 1'b1;
            end
        end
    end

    assign stat.op         = op_reg;
    assign stat.sweep_done = (cnt_reg == CW'(ENTRIES)) && !rd_ok_reg;
    assign stat.need_move  = (op_reg == OP_LOOKUP && found_reg)
                           || (op_reg == OP_ENTER && !found_reg && vic_reg);

    always_ff @(posedge clk)
    begin
        ip_rd_reg   <= ip_mem[rd_addr];
        mac_rd_reg  <= mac_mem[rd_addr];
        rank_rd_reg <= rank_mem[rd_addr];
        if (ip_we)
            ip_mem[wr_idx] <= rip_reg;
        if (mac_we)
            mac_mem[wr_idx] <= rmac_reg;
        if (cmd.update_en && rd_ok_reg)
            rank_mem[rd_idx_reg] <= rank_new;
    end

    // request, search and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            rip_reg  <= ip_addr;
            rmac_reg <= mac_addr;
            rpin_reg <= entry_permanent;
        end
        if (cmd.scan_en && rd_ok_reg)
        begin
            if (ip_match && !found_reg)
            begin
                fidx_reg  <= rd_idx_reg;
                frank_reg <= rank_eff;
                fmac_reg  <= mac_eff;
                fpin_reg  <= pinned_reg[rd_idx_reg];
            end
            if (!pinned_reg[rd_idx_reg] && (!vic_reg || rank_eff > vrank_reg))
            begin
                vidx_reg  <= rd_idx_reg;
                vrank_reg <= rank_eff;
            end
            if (mac_eff == rmac_reg && (!del_reg || rank_eff < drank_reg))
            begin
                didx_reg  <= rd_idx_reg;
                drank_reg <= rank_eff;
            end
        end
        if (cmd.decide)
        begin
            res_hit_reg    <= 1'b0;
            res_mac_reg    <= '0;
            res_status_reg <= ST_DONE;
            mv_idx_reg     <= found_reg ? fidx_reg : vidx_reg;
            mv_rank_reg    <= found_reg ? frank_reg : vrank_reg;
            case (op_reg)
                OP_LOOKUP:
                begin
                    res_hit_reg <= found_reg;
                    res_mac_reg <= found_reg ? fmac_reg : '0;
                end
                OP_ENTER:
                begin
                    if (!found_reg && !vic_reg)
                        res_status_reg <= ST_NO_ROOM;
                end
                OP_DELETE:
                begin
                    if (!del_reg)
                        res_status_reg <= ST_NO_MATCH;
                end
                default:
                begin
                    res_status_reg <= ST_DONE;
                end
            endcase
        end
        if (cmd.load_out)
        begin
            hit_reg       <= res_hit_reg;
            mac_out_reg   <= res_mac_reg;
            status_reg    <= res_status_reg;
            hit_count_reg <= hit_cnt_reg;
        end
    end

    // control state: sweep, flags, per-entry bits, hit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            rd_ok_reg   <= 1'b0;
            rd_idx_reg  <= '0;
            found_reg   <= 1'b0;
            vic_reg     <= 1'b0;
            del_reg     <= 1'b0;
            valid_reg   <= '0;
            pinned_reg  <= '0;
            macw_reg    <= '0;
            rankw_reg   <= '0;
            hit_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.sweep_clr)
            begin
                cnt_reg   <= '0;
                rd_ok_reg <= 1'b0;
            end
            else if (sweep_on)
            begin
                if (cnt_reg != CW'(ENTRIES))
                begin
                    cnt_reg    <= cnt_reg + 1'b1;
                    rd_ok_reg  <= 1'b1;
                    rd_idx_reg <= rd_addr;
                end
                else
                begin
                    rd_ok_reg <= 1'b0;
                end
            end
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
                vic_reg   <= 1'b0;
                del_reg   <= 1'b0;
            end
            if (cmd.scan_en && rd_ok_reg)
            begin
                if (ip_match)
                    found_reg <= 1'b1;
                if (!pinned_reg[rd_idx_reg])
                    vic_reg <= 1'b1;
                if (mac_eff == rmac_reg)
                    del_reg <= 1'b1;
            end
            if (cmd.update_en && rd_ok_reg)
                rankw_reg[rd_idx_reg] <= 1'b1;
            if (mac_we)
            begin
                macw_reg[wr_idx]   <= 1'b1;
                pinned_reg[wr_idx] <= rpin_reg;
            end
            if (ip_we)
                valid_reg[wr_idx] <= 1'b1;
            if (cmd.decide)
            begin
                case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (found_reg)
                            hit_cnt_reg <= hit_cnt_reg + 1'b1;
                    end
                    OP_FLUSH:
                    begin
                        valid_reg <= '0;
                    end
                    OP_DELETE:
                    begin
                        if (del_reg)
                            valid_reg[didx_reg] <= 1'b0;
                    end
                    default:
                    begin
                        hit_cnt_reg <= hit_cnt_reg;
                    end
                endcase
            end
        end
    end

    assign hit       = hit_reg;
    assign mac_out   = mac_out_reg;
    assign status    = status_reg;
    assign hit_count = hit_count_reg;

endmodule

>>> design/acl_checker.sv
// port-level checks for the address cache
// depends on acl_pkg; bound to address_cache_lru_pinned

module acl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          hit,
    input logic [acl_pkg::MAC_W-1:0]     mac_out,
    input logic [acl_pkg::STATUS_W-1:0]  status,
    input logic [acl_pkg::COUNT_W-1:0]   hit_count
);
    import acl_pkg::*;

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one in flight");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> status == ST_DONE)
        else $error("hit with nonzero status");

    a_miss_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> mac_out == '0)
        else $error("mac_out nonzero without hit");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit_count))
        else $error("stalled result changed");

endmodule

bind address_cache_lru_pinned acl_checker u_acl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .mac_out   (mac_out),
    .status    (status),
    .hit_count (hit_count)
);

>>> verif/tb.sv
// testbench for address_cache_lru_pinned: directed and random lookup/enter/flush/delete traffic
// depends on acl_pkg and the address_cache_lru_pinned rtl; predicts every result in-line

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acl_pkg::*;

    localparam int ENTRIES   = 16;
    localparam int WDOG_MAX  = 5000;
    localparam int DRAIN_CYC = 2 * ENTRIES + 10;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             pin;
    } cache_req_t;

    typedef struct {
        logic                hit;
        logic [MAC_W-1:0]    mac;
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0]  cnt;
    } cache_resp_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [OP_W-1:0]     opcode;
    logic [IP_W-1:0]     ip_addr;
    logic [MAC_W-1:0]    mac_addr;
    logic                entry_permanent;
    logic                out_valid;
    logic                out_stall;
    logic                hit;
    logic [MAC_W-1:0]    mac_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  hit_count;

    address_cache_lru_pinned #(.ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .ip_addr(ip_addr), .mac_addr(mac_addr),
        .entry_permanent(entry_permanent),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .mac_out(mac_out), .status(status), .hit_count(hit_count)
    );

    // shadow copy of the table
    logic [IP_W-1:0]    sh_ip [ENTRIES];
    logic [MAC_W-1:0]   sh_mac [ENTRIES];
    logic               sh_valid [ENTRIES];
    logic               sh_pinned [ENTRIES];
    int unsigned        sh_order [ENTRIES];
    logic [COUNT_W-1:0] sh_hits;

    cache_req_t  pending_reqs[$];
    cache_resp_t expected_resps[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  req_taken;
    int  errors;
    int  idle_cycles;
    int  n_reqs;
    int  n_resps;
    int  n_hits_seen;
    int  n_full_seen;
    int  n_del_miss;

    // small pools so lookups and deletes find something
    logic [IP_W-1:0]  ip_pool [24];
    logic [MAC_W-1:0] mac_pool [8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // move a slot to the most recent position
    task automatic promote_slot(input int unsigned slot);
        int pos;
        pos = 0;
        while (pos < ENTRIES && sh_order[pos] != slot)
            pos++;
        if (pos < ENTRIES)
        begin
            for (int k = pos; k > 0; k--)
                sh_order[k] = sh_order[k-1];
            sh_order[0] = slot;
        end
    endtask

    function automatic int find_ip(input logic [IP_W-1:0] ip);
        for (int i = 0; i < ENTRIES; i++)
            if (sh_valid[i] && sh_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // apply one request to the shadow table and queue the result it should give
    task automatic apply_cache_req(input cache_req_t r);
        cache_resp_t e;
        int s;
        int victim;
        int unsigned slot;
        e.hit = 1'b0;
        e.mac = '0;
        e.st  = ST_DONE;
        case (r.op)
            OP_LOOKUP:
            begin
                s = find_ip(r.ip);
                if (s >= 0)
                begin
                    e.hit = 1'b1;
                    e.mac = sh_mac[s];
                    promote_slot(s);
                    sh_hits = sh_hits + 1'b1;
                end
            end
            OP_ENTER:
            begin
                s = find_ip(r.ip);
                if (s >= 0)
                begin
                    // pinned match stays as it is
                    if (!sh_pinned[s])
                    begin
                        sh_pinned[s] = r.pin;
                        sh_mac[s]    = r.mac;
                    end
                end
                else
                begin
                    victim = -1;
                    for (int i = ENTRIES - 1; i >= 0; i--)
                    begin
                        slot = sh_order[i];
                        if (!sh_pinned[slot])
                        begin
                            victim = slot;
                            break;
                        end
                    end
                    if (victim < 0)
                        e.st = ST_NO_ROOM;
                    else
                    begin
                        sh_pinned[victim] = r.pin;
                        sh_valid[victim]  = 1'b1;
                        sh_ip[victim]     = r.ip;
                        sh_mac[victim]    = r.mac;
                        promote_slot(victim);
                    end
                end
            end
            OP_FLUSH:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    sh_valid[i] = 1'b0;
            end
            default:
            begin
                // delete scans in recency order, invalid slots included
                e.st = ST_NO_MATCH;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    slot = sh_order[i];
                    if (sh_mac[slot] == r.mac)
                    begin
                        sh_valid[slot] = 1'b0;
                        e.st = ST_DONE;
                        break;
                    end
                end
            end
        endcase
        e.cnt = sh_hits;
        expected_resps.push_back(e);
    endtask

    task automatic add_req(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac, input logic pin);
        cache_req_t r;
        r.op  = op;
        r.ip  = ip;
        r.mac = mac;
        r.pin = pin;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[MAC_W-1:0];
    endfunction

    task automatic add_random_req();
        int roll;
        logic [OP_W-1:0]  op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        roll = $urandom_range(99);
        if (roll < 40)
            op = OP_LOOKUP;
        else if (roll < 75)
            op = OP_ENTER;
        else if (roll < 95)
            op = OP_DELETE;
        else
            op = OP_FLUSH;
        ip  = ($urandom_range(99) < 70) ? ip_pool[$urandom_range(23)] : $urandom();
        mac = ($urandom_range(99) < 50) ? mac_pool[$urandom_range(7)] : rand_mac();
        // keep pinning rare, pinned slots never come back
        add_req(op, ip, mac, $urandom_range(99) < 1);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_resps.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    // driver: new request presented at the falling edge, held while stalled
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cache_req_t r;
                r = pending_reqs.pop_front();
                opcode          <= r.op;
                ip_addr         <= r.ip;
                mac_addr        <= r.mac;
                entry_permanent <= r.pin;
                in_valid        <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // request side: predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            cache_req_t r;
            r.op  = opcode;
            r.ip  = ip_addr;
            r.mac = mac_addr;
            r.pin = entry_permanent;
            apply_cache_req(r);
            req_taken = 1'b1;
            n_reqs++;
        end
    end

    // result side: compare against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_resps++;
            if (expected_resps.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b mac=%h status=%0d count=%0d",
                         $time, hit, mac_out, status, hit_count);
                errors++;
            end
            else
            begin
                cache_resp_t e;
                e = expected_resps.pop_front();
                if (e.hit && hit === 1'b1)
                    n_hits_seen++;
                if (e.st == ST_NO_ROOM)
                    n_full_seen++;
                if (e.st == ST_NO_MATCH)
                    n_del_miss++;
                if (hit !== e.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
                    errors++;
                end
                if (mac_out !== e.mac)
                begin
                    $display("%0t: mac_out expected %h actual %h", $time, e.mac, mac_out);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
                if (hit_count !== e.cnt)
                begin
                    $display("%0t: hit_count expected %0d actual %0d",
                             $time, e.cnt, hit_count);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, expected_resps.size());
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        out_stall       = 1'b0;
        opcode          = OP_LOOKUP;
        ip_addr         = '0;
        mac_addr        = '0;
        entry_permanent = 1'b0;
        req_taken       = 1'b0;
        errors          = 0;
        idle_cycles     = 0;
        n_reqs          = 0;
        n_resps         = 0;
        n_hits_seen     = 0;
        n_full_seen     = 0;
        n_del_miss      = 0;
        send_idle_pct   = 33;
        recv_idle_pct   = 71;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sh_ip[i]     = '0;
            sh_mac[i]    = '0;
            sh_valid[i]  = 1'b0;
            sh_pinned[i] = 1'b0;
            sh_order[i]  = i;
        end
        sh_hits = '0;
        for (int i = 0; i < 24; i++)
            ip_pool[i] = $urandom();
        ip_pool[0]  = '0;
        ip_pool[23] = '1;
        for (int i = 0; i < 8; i++)
            mac_pool[i] = rand_mac();
        mac_pool[0] = '0;
        mac_pool[7] = '1;

        // directed part
        add_req(OP_LOOKUP, 32'h0, 48'h0, 1'b0);            // miss on empty table
        add_req(OP_DELETE, 32'h0, 48'h1234_5678_9abc, 1'b0); // nothing to delete
        add_req(OP_DELETE, 32'h0, 48'h0, 1'b0);            // zero mac of a blank slot
        add_req(OP_ENTER, 32'hffff_ffff, 48'hffff_ffff_ffff, 1'b0);
        add_req(OP_ENTER, 32'h0, 48'h0000_0000_0001, 1'b0);
        add_req(OP_LOOKUP, 32'hffff_ffff, 48'h0, 1'b0);    // hit
        add_req(OP_LOOKUP, 32'h0, 48'h0, 1'b0);            // hit
        add_req(OP_ENTER, 32'h0, 48'h8000_0000_0000, 1'b0); // temporary match in place
        add_req(OP_LOOKUP, 32'h0, 48'h0, 1'b0);
        add_req(OP_ENTER, 32'h0a00_0001, 48'h0a0b_0c0d_0e0f, 1'b1); // pinned
        add_req(OP_ENTER, 32'h0a00_0001, 48'h1111_2222_3333, 1'b0); // pinned match kept
        add_req(OP_LOOKUP, 32'h0a00_0001, 48'h0, 1'b0);
        add_req(OP_DELETE, 32'h0, 48'hffff_ffff_ffff, 1'b0);
        add_req(OP_LOOKUP, 32'hffff_ffff, 48'h0, 1'b0);    // miss after delete
        add_req(OP_FLUSH, 32'h0, 48'h0, 1'b0);
        add_req(OP_LOOKUP, 32'h0a00_0001, 48'h0, 1'b0);    // miss after flush
        add_req(OP_ENTER, 32'h5555_aaaa, 48'haaaa_5555_aaaa, 1'b0);
        add_req(OP_LOOKUP, 32'h5555_aaaa, 48'h0, 1'b0);

        @(negedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // three random phases with different idle mixes
        for (int ph = 0; ph < 3; ph++)
        begin
            for (int i = 0; i < 500; i++)
                add_random_req();
            wait_drained();
            send_idle_pct = (ph == 0) ? 71 : 0;
            recv_idle_pct = (ph == 0) ? 33 : 0;
        end

        // pin the whole table, then ask for one more slot
        for (int i = 0; i < ENTRIES; i++)
            add_req(OP_ENTER, 32'hc0a8_0100 + i, rand_mac(), 1'b1);
        add_req(OP_ENTER, 32'hc0a8_0200, rand_mac(), 1'b0);
        add_req(OP_ENTER, 32'hc0a8_0103, rand_mac(), 1'b0);
        add_req(OP_LOOKUP, 32'hc0a8_0103, 48'h0, 1'b0);
        add_req(OP_FLUSH, 32'h0, 48'h0, 1'b0);
        add_req(OP_ENTER, 32'hc0a8_0201, rand_mac(), 1'b1);
        wait_drained();

        repeat (DRAIN_CYC) @(negedge clk);

        $display("tb: %0d requests, %0d results, %0d lookup hits", n_reqs, n_resps,
                 n_hits_seen);
        $display("tb: %0d full-table enters, %0d deletes with no match", n_full_seen,
                 n_del_miss);
        if (errors == 0 && expected_resps.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
